// File: hdl/sms_pkg.sv
// Shared types, constants and key helpers of the stable merge sorter.
// Depends on nothing; every other file of the block depends on it.
package sms_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int KEY_WIDTH = 32;
	localparam int VAL_W     = 32;
	localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W     = CNT_W + 2;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [CNT_W-1:0]            cnt_t;
	typedef logic [SUM_W-1:0]            sum_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		idx_t rd_addr0;
		idx_t rd_addr1;
		logic rd_bank;
		logic wr_en;
		logic wr_bank;
		idx_t wr_addr;
		logic wr_load;
		logic take_j;
		logic out_load;
		logic out_last;
		logic out_ovf;
	} dp_cmd_t;

	typedef struct packed {
		logic less;
	} dp_stat_t;

	// Truncate the sign-extended input to the key width
	function automatic key_t to_key(logic [VAL_W-1:0] v);
		logic signed [63:0] w;
		w = 64'(signed'(v));
		return w[KEY_WIDTH-1:0];
	endfunction

	// Low bits of the sign-extended key
	function automatic logic [VAL_W-1:0] key_out(key_t k);
		logic signed [63:0] w;
		w = 64'(k);
		return w[VAL_W-1:0];
	endfunction

endpackage

// File: hdl/sms_if.sv
// Valid/ready channel interfaces of the stable merge sorter.
// Depends on sms_pkg for the payload widths.
interface sms_in_if;
	logic                      valid;
	logic                      ready;
	logic [sms_pkg::VAL_W-1:0] value;
	logic                      last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface sms_out_if;
	logic                      valid;
	logic                      ready;
	logic [sms_pkg::VAL_W-1:0] sorted_value;
	logic                      last_out;
	logic                      overflow;

	modport source (output valid, output sorted_value, output last_out, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input last_out, input overflow,
		output ready);
endinterface

// File: hdl/sms_dp.sv
// Datapath of the stable merge sorter: two key banks, registered reads,
// the key comparator and the result register. Depends on sms_pkg.
module sms_dp (
	input  logic                      clk,
	input  sms_pkg::dp_cmd_t          cmd,
	output sms_pkg::dp_stat_t         stat,
	input  logic [sms_pkg::VAL_W-1:0] load_value,
	output logic [sms_pkg::VAL_W-1:0] sorted_value,
	output logic                      last_out,
	output logic                      overflow
);
	import sms_pkg::*;

	key_t bank_a [MAX_ITEMS];
	key_t bank_b [MAX_ITEMS];

	key_t a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;
	logic rd_bank_q;
	key_t rd0, rd1;
	key_t wr_data;
	logic [VAL_W-1:0] out_value_q;
	logic             out_last_q;
	logic             out_ovf_q;

	assign rd0 = rd_bank_q ? b_rd0_q : a_rd0_q;
	assign rd1 = rd_bank_q ? b_rd1_q : a_rd1_q;

	// strict compare keeps the left run first on equal keys
	assign stat.less = rd1 < rd0;

	always_comb begin
		if (cmd.wr_load) begin
			wr_data = to_key(load_value);
		end else if (cmd.take_j) begin
			wr_data = rd1;
		end else begin
			wr_data = rd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && !cmd.wr_bank) begin
			bank_a[cmd.wr_addr] <= wr_data;
		end
		a_rd0_q <= bank_a[cmd.rd_addr0];
		a_rd1_q <= bank_a[cmd.rd_addr1];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_bank) begin
			bank_b[cmd.wr_addr] <= wr_data;
		end
		b_rd0_q <= bank_b[cmd.rd_addr0];
		b_rd1_q <= bank_b[cmd.rd_addr1];
	end

	always_ff @(posedge clk) begin
		rd_bank_q <= cmd.rd_bank;
		if (cmd.out_load) begin
			out_value_q <= key_out(rd0);
			out_last_q  <= cmd.out_last;
			out_ovf_q   <= cmd.out_ovf;
		end
	end

	assign sorted_value = out_value_q;
	assign last_out     = out_last_q;
	assign overflow     = out_ovf_q;

endmodule

// File: hdl/sms_ctrl.sv
// Controller of the stable merge sorter: load, bottom-up merge passes and
// result burst sequencing. Depends on sms_pkg; drives sms_dp by commands.
module sms_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_last,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output sms_pkg::dp_cmd_t          cmd,
	input  sms_pkg::dp_stat_t         stat
);
	import sms_pkg::*;

	typedef enum logic [2:0] {
		S_LOAD,
		S_SETUP,
		S_FETCH,
		S_MERGE,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t state_q;
	cnt_t   count_q;
	logic   ovf_q;
	logic   src_q;
	sum_t   width_q;
	cnt_t   lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic   out_valid_q;

	logic   room;
	logic   take_j;
	sum_t   n_ext;
	sum_t   lo_w, lo_2w, width_2;
	cnt_t   k_inc;
	logic   k_at_end;

	assign room     = count_q < CNT_W'(MAX_ITEMS);
	assign n_ext    = SUM_W'(count_q);
	assign width_2  = width_q << 1;
	assign lo_w     = SUM_W'(lo_q) + width_q;
	assign lo_2w    = SUM_W'(lo_q) + width_2;
	assign k_inc    = k_q + CNT_W'(1);
	assign k_at_end = k_inc == count_q;
	assign take_j   = (j_q < hi_q) && ((i_q >= mid_q) || stat.less);

	assign in_ready  = state_q == S_LOAD;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.rd_bank  = src_q;
		cmd.rd_addr0 = (state_q == S_MERGE || state_q == S_FETCH) ?
			i_q[IDX_W-1:0] : k_q[IDX_W-1:0];
		cmd.rd_addr1 = j_q[IDX_W-1:0];
		cmd.out_last = k_at_end;
		cmd.out_ovf  = ovf_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.wr_en   = in_valid && room;
				cmd.wr_bank = 1'b0;
				cmd.wr_addr = count_q[IDX_W-1:0];
				cmd.wr_load = 1'b1;
			end
			S_MERGE: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_bank = !src_q;
				cmd.wr_addr = k_q[IDX_W-1:0];
				cmd.take_j  = take_j;
			end
			S_EMIT_LD: begin
				cmd.out_load = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			src_q       <= 1'b0;
			width_q     <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							width_q <= SUM_W'(1);
							lo_q    <= '0;
							k_q     <= '0;
							// a lone key needs no merging
							if (count_q == '0) begin
								state_q <= S_EMIT_RD;
							end else begin
								state_q <= S_SETUP;
							end
						end
					end
				end
				S_SETUP: begin
					mid_q   <= (lo_w < n_ext) ? lo_w[CNT_W-1:0] : count_q;
					hi_q    <= (lo_2w < n_ext) ? lo_2w[CNT_W-1:0] : count_q;
					j_q     <= (lo_w < n_ext) ? lo_w[CNT_W-1:0] : count_q;
					i_q     <= lo_q;
					k_q     <= lo_q;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					k_q <= k_inc;
					if (take_j) begin
						j_q <= j_q + CNT_W'(1);
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
					if (k_inc == hi_q) begin
						if (lo_2w >= n_ext) begin
							// pass complete: swap banks
							src_q <= !src_q;
							if (width_2 >= n_ext) begin
								k_q     <= '0;
								state_q <= S_EMIT_RD;
							end else begin
								width_q <= width_2;
								lo_q    <= '0;
								state_q <= S_SETUP;
							end
						end else begin
							lo_q    <= lo_2w[CNT_W-1:0];
							state_q <= S_SETUP;
						end
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (k_at_end) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							src_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_inc;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// File: hdl/stable_merge_sorter.sv
// Stable merge sorter: collects up to MAX_ITEMS signed keys, one per input
// transaction, until a transaction with last_item set. Input is accepted
// only while loading. The keys are then sorted by bottom-up merge passes over
// two ping-pong key banks with a single comparator: each output element of a
// pass is a registered read, then a compare and write, and each run is
// preceded by a set-up step. Each result is then read, loaded into the result
// register and held valid until the sink is ready, the last flagged by
// last_out; overflow is set on every result when keys beyond MAX_ITEMS were
// dropped. No new sequence is taken until the burst has been delivered.
// Depends on sms_pkg, sms_if, sms_ctrl and sms_dp.
module stable_merge_sorter (
	input  logic  clk,
	input  logic  arst_n,
	sms_in_if.sink    items,
	sms_out_if.source results
);
	import sms_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_last   (items.last_item),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	sms_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (stat),
		.load_value   (items.value),
		.sorted_value (results.sorted_value),
		.last_out     (results.last_out),
		.overflow     (results.overflow)
	);

endmodule
